// ----- sv/wfa_pkg.sv -----
// shared types and constants of the worst-fit block allocator
`default_nettype none
package wfa_pkg;

    localparam int INDEX_W = 4;
    localparam int SIZE_W  = 16;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

    localparam logic ACTION_LOAD    = 1'b0;
    localparam logic ACTION_REQUEST = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_LOADED    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_ALLOCATED = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NOFIT     = 2'd2;

    typedef struct packed {
        logic ge;
        logic gt;
    } wfa_cmp_t;

endpackage
`default_nettype wire

// ----- sv/wfa_cmd_if.sv -----
// command channel: load or allocation request
`default_nettype none
interface wfa_cmd_if
    import wfa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               action;
    logic [INDEX_W-1:0] block_index;
    logic [SIZE_W-1:0]  block_size;
    logic [SIZE_W-1:0]  request_size;

    modport source (output valid, output action, output block_index,
                    output block_size, output request_size, input ready);
    modport sink (input valid, input action, input block_index,
                  input block_size, input request_size, output ready);
endinterface
`default_nettype wire

// ----- sv/wfa_rsp_if.sv -----
// response channel: status, chosen block and size left
`default_nettype none
interface wfa_rsp_if
    import wfa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [INDEX_W-1:0] chosen_block;
    logic [SIZE_W-1:0]  size_left;

    modport source (output valid, output status, output chosen_block,
                    output size_left, input ready);
    modport sink (input valid, input status, input chosen_block,
                  input size_left, output ready);
endinterface
`default_nettype wire

// ----- sv/worst_fit_block_allocator.sv -----
// worst-fit block allocator top level with scan sequencer
// A load transfer writes one table entry; its response passes from the pending registers
// into the output register in ST_EMIT, and the next command is taken after that. A request
// walks the first min(block_count, NUM_BLOCKS) entries through the single table read port,
// one entry per cycle, compares each in the shared subtract/compare unit, then in ST_UPDATE
// writes back the reduced size if a block fits and passes the result on through ST_EMIT.
// A response still waiting in the output register holds the next command back while it
// stalls. The command side is ready only between items; the response register holds
// a result while the next command is taken. Table entries are undefined until loaded,
// and there is no clearing pass.
`default_nettype none
module worst_fit_block_allocator
    import wfa_pkg::*;
#(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [COUNT_W-1:0] cfg_wdata,
    wfa_cmd_if.sink                 cmd,
    wfa_rsp_if.source               rsp
);
    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE, ST_EMIT} state_t;

    state_t               state_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]     limit_reg;
    logic [CNT_W-1:0]     addr_reg;
    logic                 rd_pend_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [SIZE_BITS-1:0] best_size_reg;
    logic [SIZE_BITS-1:0] req_reg;
    logic [STAT_W-1:0]    pend_status_reg;
    logic [INDEX_W-1:0]   pend_block_reg;
    logic [SIZE_W-1:0]    pend_left_reg;
    logic                 rsp_valid_reg;
    logic [STAT_W-1:0]    rsp_status_reg;
    logic [INDEX_W-1:0]   rsp_block_reg;
    logic [SIZE_W-1:0]    rsp_left_reg;

    logic                 cmd_xfer;
    logic                 in_range;
    logic [SIZE_BITS-1:0] load_size;
    logic [CNT_W-1:0]     limit_next;
    logic                 issue;
    logic                 take;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [SIZE_BITS-1:0] mem_wdata;
    logic [SIZE_BITS-1:0] rd_data;
    logic [SIZE_BITS-1:0] unit_a;
    logic [SIZE_BITS-1:0] unit_diff;
    wfa_cmp_t             unit_cmp;

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign cmd_xfer   = cmd.valid && cmd.ready;
    assign in_range   = 32'(cmd.block_index) < NUM_BLOCKS;
    assign load_size  = SIZE_BITS'(cmd.block_size);
    assign limit_next = (32'(count_reg) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                      : CNT_W'(count_reg);
    assign issue      = (state_reg == ST_SCAN) && (addr_reg < limit_reg);
    assign unit_a     = (state_reg == ST_UPDATE) ? best_size_reg : rd_data;
    assign take       = unit_cmp.ge && (!found_reg || unit_cmp.gt);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = IDX_W'(cmd.block_index);
        mem_wdata = load_size;
        if (state_reg == ST_UPDATE)
        begin
            mem_we    = found_reg;
            mem_waddr = best_idx_reg;
            mem_wdata = unit_diff;
        end
        else if (cmd_xfer && (cmd.action == ACTION_LOAD) && in_range)
        begin
            mem_we = 1'b1;
        end
    end

    wfa_mem #(
        .DEPTH (NUM_BLOCKS),
        .WIDTH (SIZE_BITS),
        .AW    (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (addr_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    wfa_unit #(
        .WIDTH (SIZE_BITS)
    ) u_unit (
        .a    (unit_a),
        .b    (req_reg),
        .best (best_size_reg),
        .cmp  (unit_cmp),
        .diff (unit_diff)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= COUNT_RESET;
            limit_reg     <= '0;
            addr_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_xfer)
                    begin
                        if (cmd.action == ACTION_LOAD)
                        begin
                            pend_status_reg <= STATUS_LOADED;
                            pend_block_reg  <= cmd.block_index;
                            pend_left_reg   <= in_range ? SIZE_W'(load_size) : '0;
                            state_reg       <= ST_EMIT;
                        end
                        else
                        begin
                            req_reg     <= SIZE_BITS'(cmd.request_size);
                            limit_reg   <= limit_next;
                            addr_reg    <= '0;
                            rd_pend_reg <= 1'b0;
                            found_reg   <= 1'b0;
                            state_reg   <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    rd_pend_reg <= issue;
                    cmp_idx_reg <= addr_reg[IDX_W-1:0];
                    if (issue)
                    begin
                        addr_reg <= addr_reg + CNT_W'(1);
                    end
                    if (rd_pend_reg && take)
                    begin
                        found_reg     <= 1'b1;
                        best_idx_reg  <= cmp_idx_reg;
                        best_size_reg <= rd_data;
                    end
                    if (!issue && !rd_pend_reg)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    if (found_reg)
                    begin
                        pend_status_reg <= STATUS_ALLOCATED;
                        pend_block_reg  <= INDEX_W'(best_idx_reg);
                        pend_left_reg   <= SIZE_W'(unit_diff);
                    end
                    else
                    begin
                        pend_status_reg <= STATUS_NOFIT;
                        pend_block_reg  <= '0;
                        pend_left_reg   <= '0;
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= pend_status_reg;
                        rsp_block_reg  <= pend_block_reg;
                        rsp_left_reg   <= pend_left_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.chosen_block = rsp_block_reg;
    assign rsp.size_left    = rsp_left_reg;
endmodule
`default_nettype wire

// ----- sv/wfa_mem.sv -----
// free size table, one write port and one registered read port
`default_nettype none
module wfa_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ----- sv/wfa_unit.sv -----
// shared subtract and compare unit
`default_nettype none
module wfa_unit
    import wfa_pkg::*;
#(
    parameter int WIDTH = 16
) (
    input  wire logic [WIDTH-1:0] a,
    input  wire logic [WIDTH-1:0] b,
    input  wire logic [WIDTH-1:0] best,
    output wfa_cmp_t              cmp,
    output logic      [WIDTH-1:0] diff
);
    logic [WIDTH:0] sub;

    assign sub    = {1'b0, a} - {1'b0, b};
    assign diff   = sub[WIDTH-1:0];
    assign cmp.ge = ~sub[WIDTH];
    assign cmp.gt = a > best;
endmodule
`default_nettype wire

// ----- sv/wfa_checker.sv -----
// port-level checks of the worst-fit block allocator and their binding
`default_nettype none
module wfa_checker
    import wfa_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               cmd_valid,
    input wire logic               cmd_ready,
    input wire logic               rsp_valid,
    input wire logic               rsp_ready,
    input wire logic [STAT_W-1:0]  rsp_status,
    input wire logic [INDEX_W-1:0] rsp_block,
    input wire logic [SIZE_W-1:0]  rsp_left
);
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> !cmd_ready)
        else $error("command side ready right after a transfer");

    a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status == STATUS_NOFIT)) |-> (rsp_block == '0 && rsp_left == '0))
        else $error("no-fit response with nonzero block or size");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("response dropped before transfer");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            ($stable(rsp_status) && $stable(rsp_block) && $stable(rsp_left)))
        else $error("stalled response payload changed");
endmodule

bind worst_fit_block_allocator wfa_checker u_wfa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_block  (rsp.chosen_block),
    .rsp_left   (rsp.size_left)
);
`default_nettype wire
